[rtl/utx_pkg.sv]
package utx_pkg;

  typedef enum logic [1:0] {
    FMT_UTF8  = 2'd0,
    FMT_UTF16 = 2'd1,
    FMT_UTF32 = 2'd2
  } fmt_t;

  // Register select is paddr[2]
  localparam logic REG_SOURCE_FORMAT = 1'b0;
  localparam logic REG_TARGET_FORMAT = 1'b1;

  localparam logic [1:0] SOURCE_FORMAT_RST = 2'd0;
  localparam logic [1:0] TARGET_FORMAT_RST = 2'd1;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] CP_ERR    = 32'h0000_FFFD;
  localparam logic [31:0] CP_BOM    = 32'h0000_FEFF;
  localparam logic [31:0] SUPP_BASE = 32'h0001_0000;
  // 0xD800 minus (0x10000 >> 10): high surrogate straight from cp[25:10]
  localparam logic [15:0] SURR_HI_ADJ = 16'hD7C0;
  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;

  // One queue record: up to two code points decoded from one input transfer
  typedef struct packed {
    logic        two;
    logic [31:0] cp0;
    logic        end0;
    logic [31:0] cp1;
    logic        end1;
  } rec_t;

endpackage

[rtl/unicode_transcoder_core.sv]
// With an idle back end, an input transfer that yields a code point is queued and its
// result is then registered into the output register. Throughput: one input per cycle
// while each yields at most one result unit; a record is serialised one output unit
// per cycle (up to 6) while out_stall is low, and a record queue of QUEUE_DEPTH
// entries sits between decoder and encoder; input stalls while it is full.
// Reset (rst_n, synchronous, active low): queue and output empty, no pending
// sequence, source UTF-8, target UTF-16.
module unicode_transcoder_core import utx_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_code_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_out_unit,
  output logic        out_last_of_run,
  output logic        out_string_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] src_fmt_r, tgt_fmt_r;
  logic       cfg_wr, flush;
  logic       push, pop, head_valid, queue_full;
  rec_t       push_rec, head_rec;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign flush  = cfg_wr && (paddr[2] == REG_SOURCE_FORMAT);
  assign prdata = (paddr[2] == REG_TARGET_FORMAT) ? {30'd0, tgt_fmt_r} : {30'd0, src_fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= SOURCE_FORMAT_RST;
      tgt_fmt_r <= TARGET_FORMAT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SOURCE_FORMAT) src_fmt_r <= pwdata[1:0];
      else                               tgt_fmt_r <= pwdata[1:0];
    end
  end

  utx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .src_fmt      (src_fmt_r),
    .flush        (flush),
    .in_valid     (in_valid),
    .in_code_unit (in_code_unit),
    .queue_full   (queue_full),
    .in_stall     (in_stall),
    .push         (push),
    .push_rec     (push_rec)
  );

  utx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_rec   (head_rec),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  utx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .tgt_fmt         (tgt_fmt_r),
    .head_rec        (head_rec),
    .head_valid      (head_valid),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_unit    (out_out_unit),
    .out_last_of_run (out_last_of_run),
    .out_string_end  (out_string_end)
  );

endmodule

[rtl/utx_front.sv]
module utx_front import utx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  src_fmt,
  input  logic        flush,
  input  logic        in_valid,
  input  logic [31:0] in_code_unit,
  input  logic        queue_full,
  output logic        in_stall,
  output logic        push,
  output rec_t        push_rec
);

  typedef struct packed {
    logic emit;
    logic fin;
    logic lwe;
  } flt_t;

  function automatic flt_t filt(input logic [31:0] cp, input logic lwe);
    flt_t r;
    r.emit = 1'b0;
    r.fin  = 1'b0;
    r.lwe  = lwe;
    if (cp == 32'd0) begin
      r.emit = 1'b1;
      r.fin  = 1'b1;
      r.lwe  = 1'b0;
    end else if (cp != CP_BOM && !(cp == CP_ERR && lwe)) begin
      r.emit = 1'b1;
      r.lwe  = (cp == CP_ERR);
    end
    return r;
  endfunction

  logic [1:0]  pc_r, pc_nxt;
  logic [15:0] p0_r, p0_nxt;
  logic [5:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic        lwe_r, lwe_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] u;
  logic        dec_a_v, dec_f_v;
  logic [31:0] dec_a, dec_f;
  logic [1:0]  need;
  logic [21:0] v;
  logic [21:0] lim;
  logic        c0_v, c1_v;
  logic [31:0] c0, c1;
  flt_t        f0, f1;
  logic        e0, e1;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign b        = in_code_unit[7:0];
  assign u        = in_code_unit[15:0];

  always_comb begin
    unique case (p0_r[7:4])
      4'b1100, 4'b1101: need = 2'd1;
      4'b1110:          need = 2'd2;
      default:          need = 2'd3;
    endcase
    unique case (need)
      2'd1: begin
        v   = {11'd0, p0_r[4:0], b[5:0]};
        lim = 22'h80;
      end
      2'd2: begin
        v   = {6'd0, p0_r[3:0], p1_r, b[5:0]};
        lim = 22'h800;
      end
      default: begin
        v   = {p0_r[3:0], p1_r, p2_r, b[5:0]};
        lim = 22'h10000;
      end
    endcase
  end

  // Decode: dec_a resolves a pending sequence, dec_f is the unit taken afresh
  always_comb begin
    logic fresh;
    fresh   = 1'b0;
    dec_a_v = 1'b0;
    dec_a   = '0;
    dec_f_v = 1'b0;
    dec_f   = '0;
    pc_nxt  = pc_r;
    p0_nxt  = p0_r;
    p1_nxt  = p1_r;
    p2_nxt  = p2_r;
    unique case (src_fmt)
      FMT_UTF8: begin
        fresh = (pc_r == 2'd0);
        if (pc_r != 2'd0) begin
          if (b[7:6] == 2'b10) begin
            if (pc_r < need) begin
              if (pc_r == 2'd1) p1_nxt = b[5:0];
              else              p2_nxt = b[5:0];
              pc_nxt = pc_r + 2'd1;
            end else begin
              pc_nxt  = 2'd0;
              dec_a_v = 1'b1;
              dec_a   = (v < lim) ? CP_ERR : {10'd0, v};
            end
          end else begin
            // truncated: error, then the unit is taken afresh
            pc_nxt  = 2'd0;
            dec_a_v = 1'b1;
            dec_a   = CP_ERR;
            fresh   = 1'b1;
          end
        end
        if (fresh) begin
          if (!b[7]) begin
            dec_f_v = 1'b1;
            dec_f   = {24'd0, b};
          end else if (b[7:6] == 2'b11 && b[5:3] != 3'b111) begin
            p0_nxt = {8'd0, b};
            pc_nxt = 2'd1;
          end else begin
            dec_f_v = 1'b1;
            dec_f   = CP_ERR;
          end
        end
      end
      FMT_UTF16: begin
        fresh = (pc_r == 2'd0);
        if (pc_r != 2'd0) begin
          pc_nxt  = 2'd0;
          dec_a_v = 1'b1;
          if (u[15:10] == SURR_LO_TAG) begin
            dec_a = SUPP_BASE + {12'd0, p0_r[9:0], u[9:0]};
          end else begin
            dec_a = CP_ERR;
            fresh = 1'b1;
          end
        end
        if (fresh) begin
          if (u[15:10] == SURR_HI_TAG) begin
            p0_nxt = u;
            pc_nxt = 2'd1;
          end else begin
            dec_f_v = 1'b1;
            dec_f   = {16'd0, u};
          end
        end
      end
      default: begin
        dec_f_v = 1'b1;
        dec_f   = in_code_unit;
      end
    endcase
  end

  assign c0_v = dec_a_v || dec_f_v;
  assign c0   = dec_a_v ? dec_a : dec_f;
  assign c1_v = dec_a_v && dec_f_v;
  assign c1   = dec_f;

  // Drop BOM, collapse runs of U+FFFD, flag the terminator
  assign f0 = filt(c0, lwe_r);
  assign f1 = filt(c1, c0_v ? f0.lwe : lwe_r);
  assign e0 = c0_v && f0.emit;
  assign e1 = c1_v && f1.emit;

  always_comb begin
    lwe_nxt = lwe_r;
    if (c1_v)      lwe_nxt = f1.lwe;
    else if (c0_v) lwe_nxt = f0.lwe;
  end

  always_comb begin
    push_rec.two  = e0 && e1;
    push_rec.cp0  = e0 ? c0 : c1;
    push_rec.end0 = e0 ? f0.fin : f1.fin;
    push_rec.cp1  = c1;
    push_rec.end1 = f1.fin;
  end

  assign push = accept && (e0 || e1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= 2'd0;
      lwe_r <= 1'b0;
    end else if (flush) begin
      pc_r <= 2'd0;
    end else if (accept) begin
      pc_r  <= ((e0 && f0.fin) || (e1 && f1.fin)) ? 2'd0 : pc_nxt;
      lwe_r <= lwe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

  a_utf8_only_deep: assert property (@(posedge clk) disable iff (!rst_n)
    (src_fmt != FMT_UTF8) |-> (pc_r <= 2'd1))
    else $error("pending depth above one outside UTF-8");

endmodule

[rtl/utx_queue.sv]
module utx_queue import utx_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head_rec,
  output logic head_valid,
  output logic full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign head_rec   = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == FULL_CNT);

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

[rtl/utx_back.sv]
module utx_back import utx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  tgt_fmt,
  input  rec_t        head_rec,
  input  logic        head_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_out_unit,
  output logic        out_last_of_run,
  output logic        out_string_end
);

  logic        sel_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  logic [31:0] unit_r;
  logic        last_r, fin_r;

  logic [31:0] cp;
  logic        fin;
  logic [1:0]  last_idx;
  logic [1:0]  tail_pos;
  logic [5:0]  grp;
  logic [31:0] unit;
  logic        adv, cp_last, run_last;

  assign cp  = sel_r ? head_rec.cp1 : head_rec.cp0;
  assign fin = sel_r ? head_rec.end1 : head_rec.end0;

  always_comb begin
    if (fin) begin
      last_idx = 2'd0;
    end else begin
      unique case (tgt_fmt)
        FMT_UTF8: begin
          if (cp < 32'h80)         last_idx = 2'd0;
          else if (cp < 32'h800)   last_idx = 2'd1;
          else if (cp < SUPP_BASE) last_idx = 2'd2;
          else                     last_idx = 2'd3;
        end
        FMT_UTF16: last_idx = (cp >= SUPP_BASE) ? 2'd1 : 2'd0;
        default:   last_idx = 2'd0;
      endcase
    end
  end

  // continuation byte: 6-bit group counted from the tail of the sequence
  assign tail_pos = last_idx - idx_r;
  always_comb begin
    unique case (tail_pos)
      2'd0:    grp = cp[5:0];
      2'd1:    grp = cp[11:6];
      default: grp = cp[17:12];
    endcase
  end

  always_comb begin
    unit = cp;
    if (fin) begin
      unit = '0;
    end else begin
      unique case (tgt_fmt)
        FMT_UTF8: begin
          if (idx_r != 2'd0) begin
            unit = {24'd0, 2'b10, grp};
          end else begin
            unique case (last_idx)
              2'd0:    unit = {24'd0, cp[7:0]};
              2'd1:    unit = {24'd0, 3'b110, cp[10:6]};
              2'd2:    unit = {24'd0, 4'b1110, cp[15:12]};
              default: unit = {24'd0, 8'hF0 + cp[25:18]};
            endcase
          end
        end
        FMT_UTF16: begin
          if (last_idx == 2'd0)   unit = {16'd0, cp[15:0]};
          else if (idx_r == 2'd0) unit = {16'd0, SURR_HI_ADJ + cp[25:10]};
          else                    unit = {16'd0, SURR_LO_TAG, cp[9:0]};
        end
        default: unit = cp;
      endcase
    end
  end

  assign adv      = head_valid && (!out_valid_r || !out_stall);
  assign cp_last  = (idx_r == last_idx);
  assign run_last = cp_last && (sel_r || !head_rec.two);
  assign pop      = adv && run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (adv)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (adv) begin
        if (cp_last) begin
          idx_r <= 2'd0;
          sel_r <= !run_last;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r <= unit;
      last_r <= run_last;
      fin_r  <= fin;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_out_unit    = unit_r;
  assign out_last_of_run = last_r;
  assign out_string_end  = fin_r;

  a_second_cp_held: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (head_valid && head_rec.two))
    else $error("second code point selected without a two-point record");

  a_end_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fin_r) |-> (unit_r == 32'd0 && last_r))
    else $error("string end result malformed");

endmodule

[tb/tb_unicode_transcoder_core.sv]
module tb_unicode_transcoder_core;
  import utx_pkg::*;

  // Code 3 decodes and encodes as UTF-32
  localparam logic [1:0] FMT_UTF32_ALT = 2'd3;
  localparam int unsigned MAX_UNITS = 6;
  localparam int unsigned GAP_MAX = 13;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned IDLE_LIMIT = 500;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 19;
  localparam int unsigned ERR_PRINT_MAX = 40;

  localparam logic [1:0] FMT_CYCLE [4] = '{FMT_UTF8, FMT_UTF16, FMT_UTF32, FMT_UTF32_ALT};

  localparam logic [31:0] UTF8_PROBE [19] = '{
    32'h41, 32'hC3, 32'hA9, 32'hF0, 32'h9F, 32'h98, 32'h80, 32'h80, 32'hFF, 32'h5A,
    32'hC0, 32'h80, 32'hE0, 32'h41, 32'hEF, 32'hBB, 32'hBF, 32'hFFFF_FF7F, 32'h00
  };
  localparam logic [31:0] UTF16_PROBE [7] = '{
    32'hD83D, 32'hDE00, 32'hDC00, 32'hD800, 32'h41, 32'hFFFF_FFFF, 32'h0
  };
  localparam logic [31:0] UTF32_PROBE [3] = '{32'h0010_FFFF, 32'hFFFF_FFFF, 32'h0};

  typedef struct packed {
    logic [31:0] unit;
    logic        last;
    logic        str_end;
  } unit_rec_t;

  class transcode_scoreboard;
    unit_rec_t   expected_units [$];
    unit_rec_t   step_units [$];
    logic [1:0]  src_fmt;
    logic [1:0]  tgt_fmt;
    logic [15:0] pend_units [3];
    int unsigned pend_cnt;
    bit          err_run;
    int unsigned mismatches;

    function new();
      src_fmt = SOURCE_FORMAT_RST;
      tgt_fmt = TARGET_FORMAT_RST;
      pend_units = '{default: '0};
      pend_cnt = 0;
      err_run = 1'b0;
      mismatches = 0;
    endfunction

    task report(string msg);
      if (mismatches < ERR_PRINT_MAX) $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    function void write_reg(logic sel, logic [1:0] val);
      if (sel == REG_SOURCE_FORMAT) begin
        src_fmt = val;
        pend_cnt = 0;
      end else begin
        tgt_fmt = val;
      end
    endfunction

    function void put(logic [31:0] v, logic str_end);
      unit_rec_t r;
      if (step_units.size() < MAX_UNITS) begin
        r.unit = v;
        r.last = 1'b0;
        r.str_end = str_end;
        step_units.push_back(r);
      end
    endfunction

    function void encode(logic [31:0] ch);
      logic [31:0] d;
      logic [7:0]  b;
      logic [15:0] w;
      case (tgt_fmt)
        FMT_UTF8: begin
          if (ch < 32'h80) begin
            put(ch, 1'b0);
          end else if (ch < 32'h800) begin
            b = 8'hC0 + ch[13:6];
            put({24'h0, b}, 1'b0);
            put({24'h0, 2'b10, ch[5:0]}, 1'b0);
          end else if (ch < 32'h1_0000) begin
            b = 8'hE0 + ch[19:12];
            put({24'h0, b}, 1'b0);
            put({24'h0, 2'b10, ch[11:6]}, 1'b0);
            put({24'h0, 2'b10, ch[5:0]}, 1'b0);
          end else begin
            // lead byte wraps for values beyond 22 bits
            b = 8'hF0 + ch[25:18];
            put({24'h0, b}, 1'b0);
            put({24'h0, 2'b10, ch[17:12]}, 1'b0);
            put({24'h0, 2'b10, ch[11:6]}, 1'b0);
            put({24'h0, 2'b10, ch[5:0]}, 1'b0);
          end
        end
        FMT_UTF16: begin
          if (ch >= SUPP_BASE) begin
            d = ch - SUPP_BASE;
            w = 16'hD800 + d[25:10];
            put({16'h0, w}, 1'b0);
            put({16'h0, 6'b110111, d[9:0]}, 1'b0);
          end else begin
            put({16'h0, ch[15:0]}, 1'b0);
          end
        end
        default: put(ch, 1'b0);
      endcase
    endfunction

    function void emit_cp(logic [31:0] cp);
      if (cp == 32'h0) begin
        put(32'h0, 1'b1);
        pend_cnt = 0;
        err_run = 1'b0;
      end else if (cp != CP_BOM && !(cp == CP_ERR && err_run)) begin
        err_run = (cp == CP_ERR);
        encode(cp);
      end
    endfunction

    function void decode_utf8(logic [7:0] b);
      logic [7:0]  lead;
      int unsigned need;
      logic [31:0] v;
      logic [31:0] lim;
      if (pend_cnt != 0) begin
        lead = pend_units[0][7:0];
        if (b[7:6] == 2'b10) begin
          if (lead[7:5] == 3'b110) need = 1;
          else if (lead[7:4] == 4'b1110) need = 2;
          else need = 3;
          if (pend_cnt < need && pend_cnt < 3) begin
            pend_units[pend_cnt] = {8'h0, b};
            pend_cnt++;
            return;
          end
          case (need)
            1: begin
              v = {21'h0, lead[4:0], b[5:0]};
              lim = 32'h80;
            end
            2: begin
              v = {16'h0, lead[3:0], pend_units[1][5:0], b[5:0]};
              lim = 32'h800;
            end
            default: begin
              v = {10'h0, lead[3:0], pend_units[1][5:0], pend_units[2][5:0], b[5:0]};
              lim = 32'h1_0000;
            end
          endcase
          pend_cnt = 0;
          emit_cp(v < lim ? CP_ERR : v);
          return;
        end
        // truncated: flag it, then treat this byte as fresh
        pend_cnt = 0;
        emit_cp(CP_ERR);
      end
      if (b < 8'h80) begin
        emit_cp({24'h0, b});
      end else if (b[7:6] == 2'b10) begin
        emit_cp(CP_ERR);
      end else if (b[7:3] != 5'b11111) begin
        pend_units[0] = {8'h0, b};
        pend_cnt = 1;
      end else begin
        emit_cp(CP_ERR);
      end
    endfunction

    function void decode_utf16(logic [15:0] u);
      logic [15:0] hi;
      if (pend_cnt != 0) begin
        hi = pend_units[0];
        pend_cnt = 0;
        if (u >= 16'hDC00 && u < 16'hE000) begin
          emit_cp(SUPP_BASE + {12'h0, hi[9:0], u[9:0]});
          return;
        end
        emit_cp(CP_ERR);
      end
      if (u >= 16'hD800 && u < 16'hDC00) begin
        pend_units[0] = u;
        pend_cnt = 1;
      end else begin
        emit_cp({16'h0, u});
      end
    endfunction

    function void take_code_unit(logic [31:0] cu);
      unit_rec_t r;
      step_units.delete();
      case (src_fmt)
        FMT_UTF8:  decode_utf8(cu[7:0]);
        FMT_UTF16: decode_utf16(cu[15:0]);
        default:   emit_cp(cu);
      endcase
      if (step_units.size() != 0) begin
        r = step_units.pop_back();
        r.last = 1'b1;
        step_units.push_back(r);
      end
      foreach (step_units[i]) expected_units.push_back(step_units[i]);
    endfunction

    task check_unit(logic [31:0] unit, logic last, logic str_end);
      unit_rec_t want;
      if (expected_units.size() == 0) begin
        report($sformatf("unexpected result: unit %h last %b end %b", unit, last, str_end));
        return;
      end
      want = expected_units.pop_front();
      if (unit !== want.unit)
        report($sformatf("out_unit %h, expected %h", unit, want.unit));
      if (last !== want.last)
        report($sformatf("last_of_run %b, expected %b (unit %h)", last, want.last, want.unit));
      if (str_end !== want.str_end)
        report($sformatf("string_end %b, expected %b (unit %h)", str_end, want.str_end,
                         want.unit));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_code_unit = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_out_unit;
  logic        out_last_of_run;
  logic        out_string_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  transcode_scoreboard sb = new();
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  unicode_transcoder_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_unit    (in_code_unit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_unit    (out_out_unit),
    .out_last_of_run (out_last_of_run),
    .out_string_end  (out_string_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("** unicode_transcoder_core: FAILED **");
      $finish;
    end
  end

  initial begin : result_side
    int unsigned hold;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      sb.check_unit(out_out_unit, out_last_of_run, out_string_end);
    end
  end

  task automatic send_unit(logic [31:0] cu);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_unit <= cu;
    do @(posedge clk); while (in_stall);
    sb.take_code_unit(cu);
    items_sent++;
  endtask

  // Hold off until every expected unit is out, then allow for items still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup, access, then idle with psel low, so that writes never overlap
  task automatic write_reg(logic sel, logic [1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {30'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(sel, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_formats(logic [1:0] src, logic [1:0] tgt);
    drain();
    write_reg(REG_SOURCE_FORMAT, src);
    write_reg(REG_TARGET_FORMAT, tgt);
  endtask

  // One random sequence in the current source encoding, mostly well formed
  task automatic send_seq();
    logic [31:0] units [$];
    logic [31:0] cp;
    logic [31:0] noise;
    logic [7:0]  lead;
    int unsigned pick;
    int unsigned need;
    pick = $urandom_range(0, 99);
    noise = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
    case (sb.src_fmt)
      FMT_UTF8: begin
        if (pick < 60) begin
          case ($urandom_range(1, 4))
            1: begin
              cp = $urandom_range(1, 32'h7F);
              units.push_back(cp);
            end
            2: begin
              cp = $urandom_range(32'h80, 32'h7FF);
              units.push_back({24'h0, 3'b110, cp[10:6]});
              units.push_back({24'h0, 2'b10, cp[5:0]});
            end
            3: begin
              cp = $urandom_range(32'h800, 32'hFFFF);
              units.push_back({24'h0, 4'b1110, cp[15:12]});
              units.push_back({24'h0, 2'b10, cp[11:6]});
              units.push_back({24'h0, 2'b10, cp[5:0]});
            end
            default: begin
              cp = $urandom_range(32'h1_0000,
                                  ($urandom_range(0, 7) == 0) ? 32'h1F_FFFF : 32'h10_FFFF);
              units.push_back({24'h0, 5'b11110, cp[20:18]});
              units.push_back({24'h0, 2'b10, cp[17:12]});
              units.push_back({24'h0, 2'b10, cp[11:6]});
              units.push_back({24'h0, 2'b10, cp[5:0]});
            end
          endcase
        end else if (pick < 68) begin
          units.push_back($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF)
                                               : $urandom_range(8'hF8, 8'hFF));
        end else if (pick < 78) begin
          lead = 8'($urandom_range(8'hC2, 8'hF7));
          need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
          units.push_back({24'h0, lead});
          repeat ($urandom_range(0, need - 1)) units.push_back($urandom_range(8'h80, 8'hBF));
          cp = $urandom_range(0, 191);
          units.push_back(cp >= 128 ? cp + 64 : cp);
        end else if (pick < 86) begin
          case ($urandom_range(0, 2))
            0: begin
              units.push_back($urandom_range(8'hC0, 8'hC1));
              units.push_back($urandom_range(8'h80, 8'hBF));
            end
            1: begin
              units.push_back(32'hE0);
              units.push_back($urandom_range(8'h80, 8'h9F));
              units.push_back($urandom_range(8'h80, 8'hBF));
            end
            default: begin
              units.push_back(32'hF0);
              units.push_back($urandom_range(8'h80, 8'h8F));
              units.push_back($urandom_range(8'h80, 8'hBF));
              units.push_back($urandom_range(8'h80, 8'hBF));
            end
          endcase
        end else if (pick < 92) begin
          // byte order mark or a literal replacement character
          units.push_back(32'hEF);
          if ($urandom_range(0, 1)) begin
            units.push_back(32'hBB);
            units.push_back(32'hBF);
          end else begin
            units.push_back(32'hBF);
            units.push_back(32'hBD);
          end
        end else if (pick < 95) begin
          units.push_back(32'h0);
        end else begin
          units.push_back($urandom_range(0, 255));
        end
      end
      FMT_UTF16: begin
        if (pick < 55) begin
          units.push_back($urandom_range(0, 1) ? $urandom_range(1, 16'hD7FF)
                                               : $urandom_range(16'hE000, 16'hFFFF));
        end else if (pick < 72) begin
          units.push_back($urandom_range(16'hD800, 16'hDBFF));
          units.push_back($urandom_range(16'hDC00, 16'hDFFF));
        end else if (pick < 80) begin
          units.push_back($urandom_range(16'hDC00, 16'hDFFF));
        end else if (pick < 88) begin
          units.push_back($urandom_range(16'hD800, 16'hDBFF));
          case ($urandom_range(0, 2))
            0: units.push_back($urandom_range(1, 16'hD7FF));
            1: units.push_back($urandom_range(16'hD800, 16'hDBFF));
            default: units.push_back(32'h0);
          endcase
        end else if (pick < 93) begin
          units.push_back($urandom_range(0, 1) ? CP_BOM : CP_ERR);
        end else if (pick < 96) begin
          units.push_back(32'h0);
        end else begin
          noise = $urandom;
          units.push_back($urandom);
        end
      end
      default: begin
        if (pick < 60) begin
          units.push_back($urandom_range(1, 32'h10_FFFF));
        end else if (pick < 72) begin
          units.push_back($urandom);
        end else if (pick < 82) begin
          units.push_back(CP_ERR);
          if ($urandom_range(0, 1)) units.push_back(CP_ERR);
        end else if (pick < 88) begin
          units.push_back(CP_BOM);
        end else if (pick < 93) begin
          units.push_back(32'h0);
        end else begin
          units.push_back($urandom_range(16'hD800, 16'hDFFF));
        end
      end
    endcase
    // in UTF-8 and UTF-16 the unused upper bits carry noise
    foreach (units[i]) begin
      case (sb.src_fmt)
        FMT_UTF8:  send_unit({noise[31:8], units[i][7:0]});
        FMT_UTF16: send_unit({noise[31:16], units[i][15:0]});
        default:   send_unit(units[i]);
      endcase
    end
  endtask

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_formats(FMT_UTF8, FMT_UTF16);
    for (int i = 0; i < $size(UTF8_PROBE); i++) send_unit(UTF8_PROBE[i]);
    set_formats(FMT_UTF16, FMT_UTF8);
    for (int i = 0; i < $size(UTF16_PROBE); i++) send_unit(UTF16_PROBE[i]);
    set_formats(FMT_UTF32_ALT, FMT_UTF8);
    for (int i = 0; i < $size(UTF32_PROBE); i++) send_unit(UTF32_PROBE[i]);

    for (int unsigned p = 0; p < PHASES; p++) begin
      set_formats(FMT_CYCLE[p % 4], FMT_CYCLE[(p + p / 4) % 4]);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
        send_seq();
        if (p == 3 && !paused && items_sent >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("** unicode_transcoder_core: PASSED **");
    end else begin
      $display("** unicode_transcoder_core: FAILED **");
    end
    $finish;
  end

endmodule
